### src/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg: shared constants for the triangle face normal block
// Default field widths and the fixed widths of the normalized datapath.
// ----------------------------------------------------------------------------
package tfn_pkg;
  localparam int CW_DEF = 24;   // coordinate width
  localparam int NW_DEF = 16;   // normal component width
  localparam int IW_DEF = 16;   // vertex index width
  localparam int M_BITS = 31;   // normalized magnitude width
  localparam int S_BITS = 64;   // sum of squares width
  localparam int R_BITS = 32;   // square root width
  localparam int Q_BITS = 35;   // square root partial remainder width
endpackage

### src/tfn_if.sv
// ----------------------------------------------------------------------------
// tfn_in_if / tfn_out_if: triangle and normal item channels
// Valid/ready channels carrying one triangle or one face normal per item.
// ----------------------------------------------------------------------------
interface tfn_in_if #(parameter int CW = 24, parameter int IW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] ax, ay, az, bx, by_coord, bz, cx, cy, cz;
  logic        [IW-1:0] index_a, index_b, index_c;
  modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
                  index_a, index_b, index_c, input ready);
  modport sink   (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
                  index_a, index_b, index_c, output ready);
endinterface

interface tfn_out_if #(parameter int NW = 16, parameter int IW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [NW-1:0] normal_x, normal_y, normal_z;
  logic                 degenerate;
  logic        [IW-1:0] out_index_a, out_index_b, out_index_c;
  modport source (output valid, normal_x, normal_y, normal_z, degenerate,
                  out_index_a, out_index_b, out_index_c, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, degenerate,
                  out_index_a, out_index_b, out_index_c, output ready);
endinterface

### src/tfn_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tfn_sqrt_cell: one digit of the square root chain
// Consumes the top two radicand bits and settles one root bit per cell.
// ----------------------------------------------------------------------------
module tfn_sqrt_cell
  import tfn_pkg::*;
#(
  parameter int SBW = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [S_BITS-1:0] in_s,
  input  logic [Q_BITS-1:0] in_rem,
  input  logic [R_BITS-1:0] in_root,
  input  logic [SBW-1:0]    in_side,
  output logic              out_vld,
  output logic [S_BITS-1:0] out_s,
  output logic [Q_BITS-1:0] out_rem,
  output logic [R_BITS-1:0] out_root,
  output logic [SBW-1:0]    out_side
);
  logic              vld_r;
  logic [S_BITS-1:0] s_r;
  logic [Q_BITS-1:0] rem_r, rem_nxt, cur, trial;
  logic [R_BITS-1:0] root_r, root_nxt;
  logic [SBW-1:0]    side_r;
  logic              ge;

  // Try subtracting 4*root+1 from the shifted remainder
  always_comb begin
    cur      = {in_rem[Q_BITS-3:0], in_s[S_BITS-1:S_BITS-2]};
    trial    = {{(Q_BITS-R_BITS-2){1'b0}}, in_root, 2'b01};
    ge       = (cur >= trial);
    rem_nxt  = ge ? (cur - trial) : cur;
    root_nxt = {in_root[R_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r    <= {in_s[S_BITS-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= in_side;
    end
  end

  assign out_vld  = vld_r;
  assign out_s    = s_r;
  assign out_rem  = rem_r;
  assign out_root = root_r;
  assign out_side = side_r;
endmodule

### src/tfn_div_cell.sv
// ----------------------------------------------------------------------------
// tfn_div_cell: one quotient bit of the three-lane divider chain
// Each lane shifts in one numerator bit and settles one quotient bit.
// ----------------------------------------------------------------------------
module tfn_div_cell
  import tfn_pkg::*;
#(
  parameter int F   = 15,
  parameter int SBW = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [R_BITS-1:0]      in_n,
  input  logic [2:0][R_BITS-1:0] in_r,
  input  logic [2:0][F:0]        in_lq,
  input  logic [SBW-1:0]         in_side,
  output logic                   out_vld,
  output logic [R_BITS-1:0]      out_n,
  output logic [2:0][R_BITS-1:0] out_r,
  output logic [2:0][F:0]        out_lq,
  output logic [SBW-1:0]         out_side
);
  logic                   vld_r;
  logic [R_BITS-1:0]      n_r;
  logic [2:0][R_BITS-1:0] r_r, r_nxt;
  logic [2:0][F:0]        lq_r, lq_nxt;
  logic [SBW-1:0]         side_r;
  logic [R_BITS:0]        cur [3];
  logic [R_BITS:0]        dif [3];
  logic [2:0]             ge;

  // Restoring step per lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cur[i]    = {in_r[i], in_lq[i][F]};
      ge[i]     = (cur[i] >= {1'b0, in_n});
      dif[i]    = cur[i] - {1'b0, in_n};
      r_nxt[i]  = ge[i] ? dif[i][R_BITS-1:0] : cur[i][R_BITS-1:0];
      lq_nxt[i] = {in_lq[i][F-1:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r    <= in_n;
      r_r    <= r_nxt;
      lq_r   <= lq_nxt;
      side_r <= in_side;
    end
  end

  assign out_vld  = vld_r;
  assign out_n    = n_r;
  assign out_r    = r_r;
  assign out_lq   = lq_r;
  assign out_side = side_r;
endmodule

### src/triangle_face_normal.sv
// Structure: 7 front stages + 32 square root cells + NORMAL_WIDTH divider cells
//   + 1 output register.
// Throughput: one triangle per cycle; the whole pipeline advances together and
//   holds while the output register is full and not taken.
// Reset: synchronous active-low rst_n clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
// triangle_face_normal: unit face normal of a triangle
// Edge vectors, exact cross product, normalization by a digit-serial square
// root chain and a three-lane divider chain, indices passed through.
// ----------------------------------------------------------------------------
module triangle_face_normal
  import tfn_pkg::*;
#(
  parameter int COORD_WIDTH  = CW_DEF,
  parameter int NORMAL_WIDTH = NW_DEF,
  parameter int INDEX_WIDTH  = IW_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tfn_in_if.sink    in_tri,
  tfn_out_if.source out_nrm
);
  localparam int CW  = COORD_WIDTH;
  localparam int NW  = NORMAL_WIDTH;
  localparam int IW  = INDEX_WIDTH;
  localparam int F   = NW - 1;
  localparam int PW  = 2 * CW + 2;
  localparam int MW  = PW;
  localparam int LW  = $clog2(MW + 1);
  localparam int SBW = 4 + 3 * IW;
  localparam int XBW = SBW + 3 * M_BITS;
  localparam int NB  = M_BITS + 1 + F;
  localparam logic [F:0] QMAX = {1'b0, {F{1'b1}}};

  logic en;
  logic [6:0] vld_r;

  // Whole pipeline moves when the output slot is free or being taken
  assign en           = !out_nrm.valid || out_nrm.ready;
  assign in_tri.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], in_tri.valid};
    end
  end

  // Stage 1: edge vectors
  logic signed [CW:0] e1_r [3];
  logic signed [CW:0] e2_r [3];
  logic [SBW-4-1:0]   idx_r [7];

  always_ff @(posedge clk) begin
    if (en) begin
      e1_r[0] <= $signed({in_tri.bx[CW-1], in_tri.bx}) - $signed({in_tri.ax[CW-1], in_tri.ax});
      e1_r[1] <= $signed({in_tri.by_coord[CW-1], in_tri.by_coord})
                 - $signed({in_tri.ay[CW-1], in_tri.ay});
      e1_r[2] <= $signed({in_tri.bz[CW-1], in_tri.bz}) - $signed({in_tri.az[CW-1], in_tri.az});
      e2_r[0] <= $signed({in_tri.cx[CW-1], in_tri.cx}) - $signed({in_tri.ax[CW-1], in_tri.ax});
      e2_r[1] <= $signed({in_tri.cy[CW-1], in_tri.cy}) - $signed({in_tri.ay[CW-1], in_tri.ay});
      e2_r[2] <= $signed({in_tri.cz[CW-1], in_tri.cz}) - $signed({in_tri.az[CW-1], in_tri.az});
      idx_r[0] <= {in_tri.index_a, in_tri.index_b, in_tri.index_c};
      for (int k = 1; k < 7; k++) idx_r[k] <= idx_r[k-1];
    end
  end

  // Stage 2: six partial products
  logic signed [PW-1:0] p_r [6];

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= PW'(e1_r[1] * e2_r[2]);
      p_r[1] <= PW'(e1_r[2] * e2_r[1]);
      p_r[2] <= PW'(e1_r[2] * e2_r[0]);
      p_r[3] <= PW'(e1_r[0] * e2_r[2]);
      p_r[4] <= PW'(e1_r[0] * e2_r[1]);
      p_r[5] <= PW'(e1_r[1] * e2_r[0]);
    end
  end

  // Stage 3: cross components split into sign and magnitude
  logic signed [PW:0] cr [3];
  logic [PW:0]        cneg [3];
  logic [MW-1:0]      mag_r [3];
  logic [2:0]         neg_r [5];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i]   = $signed({p_r[2*i][PW-1], p_r[2*i]}) - $signed({p_r[2*i+1][PW-1], p_r[2*i+1]});
      cneg[i] = -cr[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg_r[0][i] <= cr[i][PW];
        mag_r[i]    <= cr[i][PW] ? cneg[i][MW-1:0] : cr[i][MW-1:0];
      end
      for (int k = 1; k < 5; k++) neg_r[k] <= neg_r[k-1];
    end
  end

  // Stage 4: bit length of the largest magnitude
  logic [MW-1:0] orv;
  logic [LW-1:0] len, len_r;
  logic [MW-1:0] mag4_r [3];

  always_comb begin
    orv = mag_r[0] | mag_r[1] | mag_r[2];
    len = '0;
    for (int i = 0; i < MW; i++) begin
      if (orv[i]) len = LW'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_r <= len;
      for (int i = 0; i < 3; i++) mag4_r[i] <= mag_r[i];
    end
  end

  // Stage 5: align the largest magnitude to bit 30
  logic [MW+M_BITS-1:0] sh [3];
  logic [M_BITS-1:0]    m_r [3];
  logic [M_BITS-1:0]    m6_r [3];
  logic [M_BITS-1:0]    m7_r [3];
  logic [2:0]           dgn_r;

  always_comb begin
    for (int i = 0; i < 3; i++) sh[i] = {mag4_r[i], {M_BITS{1'b0}}} >> len_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m_r[i]  <= sh[i][M_BITS-1:0];
        m6_r[i] <= m_r[i];
        m7_r[i] <= m6_r[i];
      end
      dgn_r <= {dgn_r[1:0], (len_r == '0)};
    end
  end

  // Stage 6: squares; stage 7: sum of squares
  logic [S_BITS-1:0] sq_r [3];
  logic [S_BITS-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq_r[i] <= S_BITS'(m_r[i] * m_r[i]);
      sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  // Square root chain
  logic              sv [R_BITS+1];
  logic [S_BITS-1:0] ss [R_BITS+1];
  logic [Q_BITS-1:0] sr [R_BITS+1];
  logic [R_BITS-1:0] so [R_BITS+1];
  logic [XBW-1:0]    sx [R_BITS+1];

  assign sv[0] = vld_r[6];
  assign ss[0] = sum_r;
  assign sr[0] = '0;
  assign so[0] = '0;
  assign sx[0] = {m7_r[0], m7_r[1], m7_r[2], neg_r[4], dgn_r[2], idx_r[6]};

  for (genvar g = 0; g < R_BITS; g++) begin : g_sqrt
    tfn_sqrt_cell #(.SBW(XBW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_vld(sv[g]), .in_s(ss[g]), .in_rem(sr[g]), .in_root(so[g]), .in_side(sx[g]),
      .out_vld(sv[g+1]), .out_s(ss[g+1]), .out_rem(sr[g+1]), .out_root(so[g+1]),
      .out_side(sx[g+1])
    );
  end

  // Divider setup: numerator m*2^F + n/2
  logic [M_BITS-1:0]      dm [3];
  logic [NB-1:0]          num [3];
  logic                   dv [F+2];
  logic [R_BITS-1:0]      dn [F+2];
  logic [2:0][R_BITS-1:0] dr [F+2];
  logic [2:0][F:0]        dq [F+2];
  logic [SBW-1:0]         dx [F+2];

  always_comb begin
    dm[0] = sx[R_BITS][XBW-1 -: M_BITS];
    dm[1] = sx[R_BITS][XBW-1-M_BITS -: M_BITS];
    dm[2] = sx[R_BITS][XBW-1-2*M_BITS -: M_BITS];
    for (int i = 0; i < 3; i++) begin
      num[i]   = {1'b0, dm[i], {F{1'b0}}} + NB'(so[R_BITS] >> 1);
      dr[0][i] = R_BITS'(num[i][NB-1:F+1]);
      dq[0][i] = num[i][F:0];
    end
  end

  assign dv[0] = sv[R_BITS];
  assign dn[0] = so[R_BITS];
  assign dx[0] = sx[R_BITS][SBW-1:0];

  for (genvar g = 0; g <= F; g++) begin : g_div
    tfn_div_cell #(.F(F), .SBW(SBW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_vld(dv[g]), .in_n(dn[g]), .in_r(dr[g]), .in_lq(dq[g]), .in_side(dx[g]),
      .out_vld(dv[g+1]), .out_n(dn[g+1]), .out_r(dr[g+1]), .out_lq(dq[g+1]),
      .out_side(dx[g+1])
    );
  end

  // Output register: saturate, apply sign, zero degenerate items
  logic [F:0]           qs [3];
  logic [NW-1:0]        nv [3];
  logic [2:0]           fneg;
  logic                 fdgn;
  logic                 out_vld_r;
  logic signed [NW-1:0] nx_r, ny_r, nz_r;
  logic                 dg_r;
  logic [IW-1:0]        ia_r, ib_r, ic_r;

  always_comb begin
    fneg = dx[F+1][SBW-1 -: 3];
    fdgn = dx[F+1][3*IW];
    for (int i = 0; i < 3; i++) begin
      qs[i] = (dq[F+1][i] > QMAX) ? QMAX : dq[F+1][i];
      nv[i] = fdgn ? '0 : (fneg[i] ? (-qs[i][NW-1:0]) : qs[i][NW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv[F+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r <= nv[0];
      ny_r <= nv[1];
      nz_r <= nv[2];
      dg_r <= fdgn;
      ia_r <= dx[F+1][3*IW-1 -: IW];
      ib_r <= dx[F+1][2*IW-1 -: IW];
      ic_r <= dx[F+1][IW-1:0];
    end
  end

  assign out_nrm.valid       = out_vld_r;
  assign out_nrm.normal_x    = nx_r;
  assign out_nrm.normal_y    = ny_r;
  assign out_nrm.normal_z    = nz_r;
  assign out_nrm.degenerate  = dg_r;
  assign out_nrm.out_index_a = ia_r;
  assign out_nrm.out_index_b = ib_r;
  assign out_nrm.out_index_c = ic_r;

  // A degenerate item carries a zero normal
  a_dgn_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && dg_r |-> nx_r == '0 && ny_r == '0 && nz_r == '0)
    else $error("degenerate item with nonzero normal");

  // Saturation keeps every component symmetric
  a_sym: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> nx_r != {1'b1, {F{1'b0}}} && ny_r != {1'b1, {F{1'b0}}}
                  && nz_r != {1'b1, {F{1'b0}}})
    else $error("normal component reached the negative full scale");

  // A stalled result stays put while the pipeline is frozen
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_nrm.ready |=> out_vld_r && $stable(nx_r) && $stable(ia_r))
    else $error("stalled item changed");
endmodule

### dv/tfn_checker.sv
// ----------------------------------------------------------------------------
// tfn_checker: face normal predictor and scoreboard
// Watches both channels. For each accepted triangle it computes the expected
// unit normal and queues it. Each accepted result is compared field by field
// with the oldest queued normal.
// ----------------------------------------------------------------------------
module tfn_checker
  import tfn_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  tfn_in_if         in_mon,
  tfn_out_if        out_mon,
  output int        fail_count,
  output int        normals_pending
);

  typedef struct {
    logic signed [NW_DEF-1:0] nx, ny, nz;
    logic                     degen;
    logic        [IW_DEF-1:0] ia, ib, ic;
  } normal_t;

  normal_t normals_due[$];

  assign normals_pending = normals_due.size();

  // Bit length of an unsigned magnitude
  function automatic int bit_length(input logic [63:0] v);
    int n;
    n = 0;
    while (v != 0) begin
      n++;
      v = v >> 1;
    end
    return n;
  endfunction

  // Floor of the square root, one result bit per pass
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Exact cross product of the edges, normalized and rounded to Q1.15
  function automatic normal_t face_normal(
    input logic signed [CW_DEF-1:0] ax, ay, az, bx, by, bz, cx, cy, cz,
    input logic [IW_DEF-1:0] ia, ib, ic);
    longint      e1[3], e2[3], cr[3];
    logic [63:0] mag[3], m[3];
    logic [63:0] sum, root, q;
    logic [NW_DEF-1:0] comp[3];
    int          maxlen;
    normal_t     r;
    e1[0] = longint'(bx) - longint'(ax);
    e1[1] = longint'(by) - longint'(ay);
    e1[2] = longint'(bz) - longint'(az);
    e2[0] = longint'(cx) - longint'(ax);
    e2[1] = longint'(cy) - longint'(ay);
    e2[2] = longint'(cz) - longint'(az);
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    maxlen = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (cr[i] < 0) ? -cr[i] : cr[i];
      if (bit_length(mag[i]) > maxlen) maxlen = bit_length(mag[i]);
    end
    r.ia = ia;
    r.ib = ib;
    r.ic = ic;
    r.degen = (maxlen == 0);
    r.nx = '0;
    r.ny = '0;
    r.nz = '0;
    if (maxlen != 0) begin
      // scale so the largest magnitude lands in [2^30, 2^31)
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = (maxlen > M_BITS) ? (mag[i] >> (maxlen - M_BITS))
                                 : (mag[i] << (M_BITS - maxlen));
        sum = sum + m[i] * m[i];
      end
      root = floor_sqrt(sum);
      if (root == 0) root = 1;
      for (int i = 0; i < 3; i++) begin
        q = ((m[i] << (NW_DEF - 1)) + (root >> 1)) / root;
        if (q > (64'd1 << (NW_DEF - 1)) - 1) q = (64'd1 << (NW_DEF - 1)) - 1;
        comp[i] = (cr[i] < 0) ? -q[NW_DEF-1:0] : q[NW_DEF-1:0];
      end
      r.nx = comp[0];
      r.ny = comp[1];
      r.nz = comp[2];
    end
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("normal check: %s got %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  // Queue a normal for each accepted triangle
  always @(posedge clk) begin
    if (rst_n && in_mon.valid && in_mon.ready) begin
      normals_due = {normals_due, face_normal(
        in_mon.ax, in_mon.ay, in_mon.az, in_mon.bx, in_mon.by_coord, in_mon.bz,
        in_mon.cx, in_mon.cy, in_mon.cz,
        in_mon.index_a, in_mon.index_b, in_mon.index_c)};
    end
  end

  // Compare each accepted normal with the oldest queued one
  always @(posedge clk) begin
    normal_t want;
    if (rst_n && out_mon.valid && out_mon.ready) begin
      if (normals_due.size() == 0) begin
        report("unexpected item, normal_x", out_mon.normal_x, 0);
      end else begin
        want = normals_due.pop_front();
        if (out_mon.normal_x !== want.nx) report("normal_x", out_mon.normal_x, want.nx);
        if (out_mon.normal_y !== want.ny) report("normal_y", out_mon.normal_y, want.ny);
        if (out_mon.normal_z !== want.nz) report("normal_z", out_mon.normal_z, want.nz);
        if (out_mon.degenerate !== want.degen)
          report("degenerate", out_mon.degenerate, want.degen);
        if (out_mon.out_index_a !== want.ia) report("out_index_a", out_mon.out_index_a, want.ia);
        if (out_mon.out_index_b !== want.ib) report("out_index_b", out_mon.out_index_b, want.ib);
        if (out_mon.out_index_c !== want.ic) report("out_index_c", out_mon.out_index_c, want.ic);
      end
    end
  end

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: triangle face normal testbench
// Drives directed and random triangles with random idle bursts and one long
// output hold-off; the checker predicts and compares every normal.
// ----------------------------------------------------------------------------
module tb_top
  import tfn_pkg::*;
();

  localparam int NUM_RANDOM  = 380;
  localparam int CALM_AFTER  = 340;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 80;
  localparam int CYCLE_LIMIT = 200000;
  localparam int COORD_MAX   = (1 << (CW_DEF - 1)) - 1;
  localparam int COORD_MIN   = -(1 << (CW_DEF - 1));

  logic clk;
  logic rst_n;
  int   fail_count;
  int   normals_pending;
  int   tris_sent;
  int   cycle_count;
  bit   calm;

  tfn_in_if  #(.CW(CW_DEF), .IW(IW_DEF)) in_tri ();
  tfn_out_if #(.NW(NW_DEF), .IW(IW_DEF)) out_nrm ();

  triangle_face_normal u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tri  (in_tri.sink),
    .out_nrm (out_nrm.source)
  );

  tfn_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_tri),
    .out_mon         (out_nrm),
    .fail_count      (fail_count),
    .normals_pending (normals_pending)
  );

  // Clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Cycle limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("triangle_face_normal: mismatch");
      $finish;
    end
  end

  // Offer one triangle and hold it until accepted
  task automatic send_tri(input int v[9], input logic [IW_DEF-1:0] ia, ib, ic);
    @(negedge clk);
    in_tri.valid    = 1'b1;
    in_tri.ax       = v[0][CW_DEF-1:0];
    in_tri.ay       = v[1][CW_DEF-1:0];
    in_tri.az       = v[2][CW_DEF-1:0];
    in_tri.bx       = v[3][CW_DEF-1:0];
    in_tri.by_coord = v[4][CW_DEF-1:0];
    in_tri.bz       = v[5][CW_DEF-1:0];
    in_tri.cx       = v[6][CW_DEF-1:0];
    in_tri.cy       = v[7][CW_DEF-1:0];
    in_tri.cz       = v[8][CW_DEF-1:0];
    in_tri.index_a  = ia;
    in_tri.index_b  = ib;
    in_tri.index_c  = ic;
    do @(posedge clk); while (!in_tri.ready);
    tris_sent++;
    // drop valid for a random burst now and then
    if (!calm && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_tri.valid = 1'b0;
      repeat ($urandom_range(1, 19) - 1) @(negedge clk);
    end
  endtask

  function automatic int any_coord();
    return $signed($urandom_range(0, (1 << CW_DEF) - 1) << (32 - CW_DEF)) >>> (32 - CW_DEF);
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(0, 3))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return 0;
      default: return any_coord();
    endcase
  endfunction

  // Random triangle: mostly well formed, with degenerate and extreme shapes
  task automatic send_random_tri();
    int v[9];
    int d[3];
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) v[i] = any_coord();
    case (kind)
      4, 5: begin
        // small triangle around a random point
        for (int i = 3; i < 9; i++)
          v[i] = v[i % 3] / 2 + $signed($urandom_range(0, 8191)) - 4096;
        for (int i = 0; i < 3; i++) v[i] = v[i] / 2;
      end
      6: begin
        // collinear or coincident corners
        for (int i = 0; i < 3; i++) begin
          d[i] = $urandom_range(0, 1) ? 0 : $signed($urandom_range(0, 65535)) - 32768;
          v[i] = v[i] / 4;
          v[3 + i] = v[i] + d[i];
          v[6 + i] = v[i] + 2 * d[i];
        end
      end
      7: begin
        // edges along two axes
        v[3] = v[0] + $signed($urandom_range(1, 4096)) * ($urandom_range(0, 1) ? 1 : -1);
        v[4] = v[1];
        v[5] = v[2];
        v[6] = v[0];
        v[7] = v[1] + $signed($urandom_range(1, 4096)) * ($urandom_range(0, 1) ? 1 : -1);
        v[8] = v[2];
      end
      8, 9: begin
        for (int i = 0; i < 9; i++) v[i] = extreme_coord();
      end
      default: ;
    endcase
    send_tri(v, IW_DEF'($urandom_range(0, 65535)), IW_DEF'($urandom_range(0, 65535)),
             IW_DEF'($urandom_range(0, 65535)));
  endtask

  // Result side: random stall bursts and one long hold-off
  initial begin
    bit held;
    held = 0;
    out_nrm.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && tris_sent >= 100) begin
        held = 1;
        out_nrm.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_nrm.ready = 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk);
      end else begin
        out_nrm.ready = 1'b1;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int v[9];
    tris_sent = 0;
    calm = 0;
    rst_n = 1'b0;
    in_tri.valid = 1'b0;
    {in_tri.ax, in_tri.ay, in_tri.az, in_tri.bx, in_tri.by_coord, in_tri.bz,
     in_tri.cx, in_tri.cy, in_tri.cz} = '0;
    {in_tri.index_a, in_tri.index_b, in_tri.index_c} = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // unit triangle in the xy plane: normal saturates at +z
    v = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0};
    send_tri(v, 16'h0000, 16'hFFFF, 16'h0000);
    // reversed winding: saturates at -z
    v = '{0, 0, 0, 0, 4096, 0, 4096, 0, 0};
    send_tri(v, 16'hFFFF, 16'h0000, 16'hFFFF);
    // unit triangles on the other two planes
    v = '{0, 0, 0, 0, 4096, 0, 0, 0, 4096};
    send_tri(v, 1, 2, 3);
    v = '{0, 0, 0, 0, 0, 4096, 4096, 0, 0};
    send_tri(v, 4, 5, 6);
    // coincident corners: degenerate
    v = '{COORD_MAX, COORD_MIN, 0, COORD_MAX, COORD_MIN, 0, COORD_MAX, COORD_MIN, 0};
    send_tri(v, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // collinear corners: degenerate
    v = '{-100, 200, -300, 0, 0, 0, 100, -200, 300};
    send_tri(v, 7, 8, 9);
    // extreme edges, largest cross magnitudes
    v = '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN,
          COORD_MIN, COORD_MAX, COORD_MIN};
    send_tri(v, 10, 11, 12);
    v = '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX,
          COORD_MAX, COORD_MIN, COORD_MAX};
    send_tri(v, 13, 14, 15);
    v = '{COORD_MIN, COORD_MAX, 0, COORD_MAX, COORD_MIN, COORD_MAX,
          0, COORD_MIN, COORD_MIN};
    send_tri(v, 0, 65535, 32768);
    // smallest nonzero cross product
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_tri(v, 32767, 1, 2);
    // diagonal normal with equal components
    v = '{4096, 0, 0, 0, 4096, 0, 0, 0, 4096};
    send_tri(v, 3, 2, 1);
    v = '{-4096, 0, 0, 0, -4096, 0, 0, 0, -4096};
    send_tri(v, 100, 200, 300);

    for (int k = 0; k < NUM_RANDOM; k++) begin
      if (k >= CALM_AFTER) calm = 1;
      send_random_tri();
    end
    @(negedge clk);
    in_tri.valid = 1'b0;

    // drain and let the pipeline settle
    while (normals_pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && normals_pending == 0) begin
      $display("triangle_face_normal: match");
    end else begin
      $display("triangle_face_normal: mismatch");
    end
    $finish;
  end

endmodule
